@@ src/lcdnws_pkg.sv @@
// Package: shared types, constants and tables of the LCD nibble write sequencer.
`default_nettype none
package lcdnws_pkg;

  localparam int KIND_W   = 3;
  localparam int VALUE_W  = 8;
  localparam int COLUMN_W = 6;
  localparam int ROW_W    = 2;
  localparam int BUS_W    = 8;
  localparam int LWA_W    = 2;

  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int INIT_CMDS       = 6;

  localparam logic [BUS_W-1:0] BIT_RS = 8'h40;
  localparam logic [BUS_W-1:0] BIT_RW = 8'h20;
  localparam logic [BUS_W-1:0] BIT_EN = 8'h10;
  localparam logic [BUS_W-1:0] NIBBLE = 8'h0f;

  localparam logic [VALUE_W-1:0] CMD_CLEAR = 8'h01;

  typedef enum logic [KIND_W-1:0] {
    KIND_CMD    = 3'd0,
    KIND_DATA   = 3'd1,
    KIND_CURSOR = 3'd2,
    KIND_INIT   = 3'd3,
    KIND_CLEAR  = 3'd4
  } kind_t;

  // One byte to send, with the wait marks of its first and last write.
  typedef struct packed {
    logic [VALUE_W-1:0] byte_val;
    logic               is_data;
    logic               long_before;
    logic [LWA_W-1:0]   long_after;
    logic               last;
  } byte_req_t;

  // Handshake between the front part and the queue.
  typedef struct packed {
    logic      valid;
    byte_req_t req;
  } push_t;

  function automatic logic [VALUE_W-1:0] init_cmd(input logic [2:0] idx);
    logic [VALUE_W-1:0] c;
    case (idx)
      3'd0:    c = 8'h33;
      3'd1:    c = 8'h32;
      3'd2:    c = 8'h28;
      3'd3:    c = 8'h0c;
      3'd4:    c = 8'h06;
      default: c = 8'h01;
    endcase
    return c;
  endfunction

  function automatic logic [VALUE_W-1:0] row_base(input logic [ROW_W-1:0] row);
    logic [VALUE_W-1:0] b;
    case (row)
      2'd0:    b = 8'h80;
      2'd1:    b = 8'hc0;
      2'd2:    b = 8'h94;
      default: b = 8'hd4;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

@@ src/lcdnws_ifs.sv @@
// Interfaces: request, result and configuration channels of the sequencer.
`default_nettype none
interface lcdnws_in_if;
  logic                           valid;
  logic                           ready;
  logic [lcdnws_pkg::KIND_W-1:0]   kind;
  logic [lcdnws_pkg::VALUE_W-1:0]  value;
  logic [lcdnws_pkg::COLUMN_W-1:0] column;
  logic [lcdnws_pkg::ROW_W-1:0]    row;
  modport source (output valid, kind, value, column, row, input ready);
  modport sink   (input valid, kind, value, column, row, output ready);
endinterface

interface lcdnws_out_if;
  logic                          valid;
  logic                          ready;
  logic [lcdnws_pkg::BUS_W-1:0]  bus_word;
  logic                          short_wait_before;
  logic                          long_waits_before;
  logic [lcdnws_pkg::LWA_W-1:0]  long_waits_after;
  logic                          last;
  modport source (output valid, bus_word, short_wait_before, long_waits_before,
                  long_waits_after, last, input ready);
  modport sink   (input valid, bus_word, short_wait_before, long_waits_before,
                  long_waits_after, last, output ready);
endinterface

interface lcdnws_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

@@ src/lcdnws_front.sv @@
// Front part: accept requests, classify them and push the bytes to send.
`default_nettype none
module lcdnws_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             waits_en,
  lcdnws_in_if.sink             in_req,
  output lcdnws_pkg::push_t     push,
  input  wire logic             push_ready
);
  import lcdnws_pkg::*;

  logic [2:0] init_cnt_r, init_cnt_nxt;
  logic       accept;
  byte_req_t  req;
  logic       req_valid;

  assign in_req.ready = (init_cnt_r == 3'd0) && push_ready;
  assign accept       = in_req.valid && in_req.ready;

  always_comb begin
    req          = '0;
    req_valid    = 1'b0;
    init_cnt_nxt = init_cnt_r;
    if (init_cnt_r != 3'd0) begin
      // Continue the init run, one command a cycle while the queue has room.
      req.byte_val   = init_cmd(init_cnt_r);
      req.long_after = (init_cnt_r == 3'(INIT_CMDS - 1)) ? 2'd2 : 2'd1;
      req.last       = (init_cnt_r == 3'(INIT_CMDS - 1));
      req_valid      = 1'b1;
      if (push_ready) begin
        init_cnt_nxt = req.last ? 3'd0 : init_cnt_r + 3'd1;
      end
    end else if (accept) begin
      req.last  = 1'b1;
      req_valid = 1'b1;
      case (in_req.kind)
        KIND_CMD:    req.byte_val = in_req.value;
        KIND_DATA: begin
          req.byte_val = in_req.value;
          req.is_data  = 1'b1;
        end
        KIND_CURSOR: req.byte_val = row_base(in_req.row) + {2'b00, in_req.column};
        KIND_INIT: begin
          req.byte_val   = init_cmd(3'd0);
          req.long_after = 2'd1;
          req.last       = 1'b0;
          init_cnt_nxt   = 3'd1;
        end
        KIND_CLEAR: begin
          req.byte_val    = CMD_CLEAR;
          req.long_before = 1'b1;
          req.long_after  = 2'd1;
        end
        default: req_valid = 1'b0;  // drop unknown kinds
      endcase
    end
    if (!waits_en) begin
      req.long_before = 1'b0;
      req.long_after  = '0;
    end
  end

  assign push.valid = req_valid;
  assign push.req   = req;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_cnt_r <= 3'd0;
    end else begin
      init_cnt_r <= init_cnt_nxt;
    end
  end
endmodule
`default_nettype wire

@@ src/lcdnws_queue.sv @@
// Queue: short FIFO of byte requests between the front and back parts.
`default_nettype none
module lcdnws_queue #(
  parameter int DEPTH = lcdnws_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire lcdnws_pkg::push_t push,
  output logic                   push_ready,
  output logic                   head_valid,
  output lcdnws_pkg::byte_req_t  head,
  input  wire logic              pop
);
  import lcdnws_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  byte_req_t        mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem[rd_ptr_r];
  assign do_push    = push.valid && push_ready;
  assign do_pop     = pop && head_valid;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push.req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (do_pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ src/lcdnws_back.sv @@
// Back part: step the shadow byte through the eight bus writes of each byte.
`default_nettype none
module lcdnws_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  waits_en,
  input  wire logic                  head_valid,
  input  wire lcdnws_pkg::byte_req_t head,
  output logic                       pop,
  lcdnws_out_if.source               out_res
);
  import lcdnws_pkg::*;

  localparam logic [2:0] STEP_LAST = 3'd7;

  logic [2:0]       step_r;
  logic [BUS_W-1:0] shadow_r, shadow_nxt;
  logic             out_valid_r;
  logic [BUS_W-1:0] bus_word_r;
  logic             swb_r, lwb_r, last_r;
  logic [LWA_W-1:0] lwa_r;
  logic             advance;

  assign advance = head_valid && (!out_valid_r || out_res.ready);
  assign pop     = advance && (step_r == STEP_LAST);

  always_comb begin
    shadow_nxt = shadow_r;
    case (step_r)
      3'd0: shadow_nxt = shadow_r & ~(BIT_EN | BIT_RW);
      3'd1: shadow_nxt = head.is_data ? (shadow_r | BIT_RS) : (shadow_r & ~BIT_RS);
      3'd2: shadow_nxt = (shadow_r & ~NIBBLE) | {4'h0, head.byte_val[7:4]};
      3'd3: shadow_nxt = shadow_r | BIT_EN;
      3'd4: shadow_nxt = shadow_r & ~BIT_EN;
      3'd5: shadow_nxt = (shadow_r & ~NIBBLE) | {4'h0, head.byte_val[3:0]};
      3'd6: shadow_nxt = shadow_r | BIT_EN;
      default: shadow_nxt = shadow_r & ~BIT_EN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= 3'd0;
      shadow_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_res.ready) out_valid_r <= 1'b0;
      if (advance) begin
        step_r      <= step_r + 3'd1;
        shadow_r    <= shadow_nxt;
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      bus_word_r <= shadow_nxt;
      swb_r      <= waits_en && (step_r != 3'd1);
      lwb_r      <= (step_r == 3'd0) && head.long_before;
      lwa_r      <= (step_r == STEP_LAST) ? head.long_after : '0;
      last_r     <= (step_r == STEP_LAST) && head.last;
    end
  end

  assign out_res.valid             = out_valid_r;
  assign out_res.bus_word          = bus_word_r;
  assign out_res.short_wait_before = swb_r;
  assign out_res.long_waits_before = lwb_r;
  assign out_res.long_waits_after  = lwa_r;
  assign out_res.last              = last_r;
endmodule
`default_nettype wire

@@ src/lcd_nibble_write_sequencer.sv @@
// Top level: LCD nibble write sequencer for a 4-bit character LCD bus.
// in_req carries one request (command, data, cursor move, init or clear).
// out_res carries one bus write per result: the pin byte (d4-d7 in bits 0-3,
// EN bit 4, RW bit 5, RS bit 6, backlight bit 7) with its wait marks; last
// flags the final write of a request. cfg_wr writes waits_enabled (reset 1);
// write it only while the block is idle. cfg_wr is always ready.
// Each byte takes eight bus writes, set by the back part's step counter;
// init sends six bytes. A request's first write passes the queue register,
// then the output register, before out_res shows it. Unknown kinds
// are taken and dropped. A request is taken whenever the front part is not
// in an init run and the queue has a free slot, so requests keep coming in
// while the back part works or the receiver stalls; a stall on out_res only
// holds the output register and the back step. Reset clears the shadow byte
// (backlight stays off), the queue and all handshake state.
`default_nettype none
module lcd_nibble_write_sequencer #(
  parameter int QUEUE_DEPTH = lcdnws_pkg::QUEUE_DEPTH_DEF
) (
  input wire logic      clk,
  input wire logic      rst_n,
  lcdnws_in_if.sink     in_req,
  lcdnws_out_if.source  out_res,
  lcdnws_cfg_if.sink    cfg_wr
);
  import lcdnws_pkg::*;

  logic      waits_en_r;
  push_t     push;
  logic      push_ready;
  logic      head_valid;
  byte_req_t head;
  logic      pop;

  // Configuration: a single bit, always accepted.
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waits_en_r <= 1'b1;
    end else if (cfg_wr.valid) begin
      waits_en_r <= cfg_wr.data;
    end
  end

  // Classify requests into byte sends.
  lcdnws_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .waits_en   (waits_en_r),
    .in_req     (in_req),
    .push       (push),
    .push_ready (push_ready)
  );

  // Decouple front and back.
  lcdnws_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  // Expand each byte into eight bus writes.
  lcdnws_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .waits_en   (waits_en_r),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_res    (out_res)
  );
endmodule
`default_nettype wire
